@@ hw/rtl/event_pair_lease_allocator_assert.svh @@
// Assertion macros shared by the event pair lease allocator RTL.
`ifndef EVENT_PAIR_LEASE_ALLOCATOR_ASSERT_SVH
`define EVENT_PAIR_LEASE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define EPLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("event_pair_lease_allocator: assertion failed");

// next-cycle implication
`define EPLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("event_pair_lease_allocator: assertion failed");

`endif

@@ hw/rtl/epla_pkg.sv @@
// Shared types and constants for the event pair lease allocator.
package epla_pkg;

  localparam int EVENT_COUNT_DEF = 64;
  localparam int SLOT_W          = 8;
  localparam int LEASE_W         = 32;
  localparam int Q_DEPTH         = 2;
  localparam int Q_PTR_W         = 1;

  // request type field codes
  localparam logic [1:0] REQ_INIT    = 2'd0;
  localparam logic [1:0] REQ_RESERVE = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  // classified operation codes
  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_RESERVE = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_REJECT  = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [SLOT_W-1:0]  first_index;
    logic [SLOT_W-1:0]  second_index;
    logic [LEASE_W-1:0] lease;
  } cmd_t;

endpackage

@@ hw/rtl/epla_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module epla_ram
  import epla_pkg::*;
#(
  parameter int WIDTH = LEASE_W,
  parameter int DEPTH = EVENT_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

@@ hw/rtl/epla_front.sv @@
// Front end: accepts requests and classifies them into commands.
module epla_front
  import epla_pkg::*;
#(
  parameter int EVENT_COUNT = EVENT_COUNT_DEF
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [SLOT_W-1:0]  in_first_index,
  input  logic [SLOT_W-1:0]  in_second_index,
  input  logic [LEASE_W-1:0] in_lease_in,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd
);

  logic first_ok;
  logic second_ok;
  logic release_ok;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign first_ok   = {1'b0, in_first_index} < (SLOT_W + 1)'(EVENT_COUNT);
  assign second_ok  = {1'b0, in_second_index} < (SLOT_W + 1)'(EVENT_COUNT);
  // checks that need no pool state are settled here
  assign release_ok = first_ok && second_ok && (in_first_index != in_second_index)
                      && (in_lease_in != '0);

  always_comb begin
    q_cmd.first_index  = in_first_index;
    q_cmd.second_index = in_second_index;
    q_cmd.lease        = in_lease_in;
    unique case (in_req_type)
      REQ_INIT:    q_cmd.op = OP_INIT;
      REQ_RESERVE: q_cmd.op = OP_RESERVE;
      REQ_RELEASE: q_cmd.op = release_ok ? OP_RELEASE : OP_REJECT;
      default:     q_cmd.op = OP_REJECT;
    endcase
  end

endmodule

@@ hw/rtl/epla_queue.sv @@
// Two-entry command queue between front end and execution unit.
module epla_queue
  import epla_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t               entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;
  logic [Q_PTR_W:0]   count_nxt;

  assign full       = count_r == (Q_PTR_W + 1)'(Q_DEPTH);
  assign head_valid = count_r != '0;
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/epla_back.sv @@
// Execution unit: pool state, lease memory and result register.
module epla_back
  import epla_pkg::*;
#(
  parameter int EVENT_COUNT = EVENT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic [SLOT_W-1:0]  out_first_slot,
  output logic [SLOT_W-1:0]  out_second_slot,
  output logic [LEASE_W-1:0] out_lease_out
);

  localparam int IDX_W = $clog2(EVENT_COUNT);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RES     = 3'd1;
  localparam logic [2:0] S_RES_WR  = 3'd2;
  localparam logic [2:0] S_REL_CHK = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [EVENT_COUNT-1:0] map_r, map_nxt;
  logic [LEASE_W-1:0]     cnt_r, cnt_nxt;
  logic                   rdy_r, rdy_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [IDX_W-1:0]       lo_r, lo_nxt;
  logic                   res_ok_r, res_ok_nxt;
  logic [SLOT_W-1:0]      res_first_r, res_first_nxt;
  logic [SLOT_W-1:0]      res_second_r, res_second_nxt;
  logic [LEASE_W-1:0]     res_lease_r, res_lease_nxt;

  logic                   out_valid_r;
  logic                   out_ok_r;
  logic [SLOT_W-1:0]      out_first_r;
  logic [SLOT_W-1:0]      out_second_r;
  logic [LEASE_W-1:0]     out_lease_r;
  logic                   out_load;

  logic [EVENT_COUNT-1:0] search_vec;
  logic                   find_ok;
  logic [IDX_W-1:0]       find_idx;
  logic [LEASE_W-1:0]     token;

  logic [IDX_W-1:0]       head_a, head_b, cmd_a, cmd_b;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [LEASE_W-1:0]     ram_wdata;
  logic [LEASE_W-1:0]     rd_a, rd_b;

  function automatic logic [EVENT_COUNT-1:0] slot_bit(input logic [IDX_W-1:0] idx);
    slot_bit = EVENT_COUNT'(1) << idx;
  endfunction

  assign head_a = q_cmd.first_index[IDX_W-1:0];
  assign head_b = q_cmd.second_index[IDX_W-1:0];
  assign cmd_a  = cmd_r.first_index[IDX_W-1:0];
  assign cmd_b  = cmd_r.second_index[IDX_W-1:0];

  // second pass masks the slot found in the first
  assign search_vec = (state_r == S_RES) ? (map_r | slot_bit(lo_r)) : map_r;
  assign token      = (cnt_r == '0) ? LEASE_W'(1) : cnt_r;

  always_comb begin
    find_ok  = 1'b0;
    find_idx = '0;
    for (int i = EVENT_COUNT - 1; i >= 0; i--) begin
      if (!search_vec[i]) begin
        find_ok  = 1'b1;
        find_idx = IDX_W'(i);
      end
    end
  end

  epla_ram #(
    .WIDTH (LEASE_W),
    .DEPTH (EVENT_COUNT)
  ) u_lease_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (head_a),
    .raddr_b (head_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    map_nxt        = map_r;
    cnt_nxt        = cnt_r;
    rdy_nxt        = rdy_r;
    cmd_nxt        = cmd_r;
    lo_nxt         = lo_r;
    res_ok_nxt     = res_ok_r;
    res_first_nxt  = res_first_r;
    res_second_nxt = res_second_r;
    res_lease_nxt  = res_lease_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = lo_r;
    ram_wdata      = res_lease_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          cmd_nxt        = q_cmd;
          res_ok_nxt     = 1'b0;
          res_first_nxt  = '0;
          res_second_nxt = '0;
          res_lease_nxt  = '0;
          state_nxt      = S_DONE;
          case (q_cmd.op)
            OP_INIT: begin
              map_nxt    = '0;
              cnt_nxt    = LEASE_W'(1);
              rdy_nxt    = 1'b1;
              res_ok_nxt = 1'b1;
            end
            OP_RESERVE: begin
              if (rdy_r && find_ok) begin
                lo_nxt    = find_idx;
                state_nxt = S_RES;
              end
            end
            OP_RELEASE: begin
              // lease words are read this cycle, compared in the next
              if (rdy_r && map_r[head_a] && map_r[head_b]) begin
                state_nxt = S_REL_CHK;
              end
            end
            default: ;
          endcase
        end
      end
      S_RES: begin
        state_nxt = S_DONE;
        if (find_ok) begin
          cnt_nxt        = token + 1'b1;
          map_nxt        = map_r | slot_bit(lo_r) | slot_bit(find_idx);
          ram_we         = 1'b1;
          ram_waddr      = lo_r;
          ram_wdata      = token;
          res_ok_nxt     = 1'b1;
          res_first_nxt  = SLOT_W'(lo_r);
          res_second_nxt = SLOT_W'(find_idx);
          res_lease_nxt  = token;
          state_nxt      = S_RES_WR;
        end
      end
      S_RES_WR: begin
        ram_we    = 1'b1;
        ram_waddr = res_second_r[IDX_W-1:0];
        ram_wdata = res_lease_r;
        state_nxt = S_DONE;
      end
      S_REL_CHK: begin
        if ((rd_a == cmd_r.lease) && (rd_b == cmd_r.lease)) begin
          map_nxt    = map_r & ~(slot_bit(cmd_a) | slot_bit(cmd_b));
          res_ok_nxt = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      map_r       <= '0;
      cnt_r       <= '0;
      rdy_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      map_r   <= map_nxt;
      cnt_r   <= cnt_nxt;
      rdy_r   <= rdy_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    lo_r         <= lo_nxt;
    res_ok_r     <= res_ok_nxt;
    res_first_r  <= res_first_nxt;
    res_second_r <= res_second_nxt;
    res_lease_r  <= res_lease_nxt;
    if (out_load) begin
      out_ok_r     <= res_ok_r;
      out_first_r  <= res_first_r;
      out_second_r <= res_second_r;
      out_lease_r  <= res_lease_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_first_slot  = out_first_r;
  assign out_second_slot = out_second_r;
  assign out_lease_out   = out_lease_r;

endmodule

@@ hw/rtl/event_pair_lease_allocator.sv @@
// Top level of the event pair lease allocator.
// Hands out event slots in pairs from a pool of EVENT_COUNT slots, each pair
// stamped with a nonzero lease token; a pair is released by quoting both slots
// and the token. Requests fail until an initialize request is made, and each
// request returns exactly one result. The front end checks the request fields
// and queues up to two commands, so the input keeps accepting while the
// execution unit works. The execution unit handles one command at a time, and
// its last cycle on a command loads the output register. Initialize, rejected
// requests and a reserve or release refused on the reserved bits go from idle
// straight to the result state; a release that compares lease words passes
// a check state first (the lease memory read is registered); a reserve that
// finds only one free slot passes the second search state; a granted reserve
// passes the second search and then a second write state (two passes of the
// free-slot search and two writes through the single lease memory write
// port). The next command starts on the cycle after a result is loaded. A
// result held off at the output stalls the execution unit; the queue then fills
// and in_ready drops. No clearing pass is needed after reset or initialize:
// the reserved bits are flip-flops and gate every use of the lease memory.
`include "event_pair_lease_allocator_assert.svh"
module event_pair_lease_allocator
  import epla_pkg::*;
#(
  parameter int EVENT_COUNT = EVENT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [SLOT_W-1:0]  in_first_index,
  input  logic [SLOT_W-1:0]  in_second_index,
  input  logic [LEASE_W-1:0] in_lease_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic [SLOT_W-1:0]  out_first_slot,
  output logic [SLOT_W-1:0]  out_second_slot,
  output logic [LEASE_W-1:0] out_lease_out
);

  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(EVENT_COUNT - 1);

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  logic out_has_lease;
  logic out_grant_ok;
  logic out_no_slots;
  logic out_in_pool;

  epla_front #(
    .EVENT_COUNT (EVENT_COUNT)
  ) u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_first_index  (in_first_index),
    .in_second_index (in_second_index),
    .in_lease_in     (in_lease_in),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_push_cmd)
  );

  epla_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  epla_back #(
    .EVENT_COUNT (EVENT_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_first_slot  (out_first_slot),
    .out_second_slot (out_second_slot),
    .out_lease_out   (out_lease_out)
  );

  assign out_has_lease = out_lease_out != '0;
  assign out_grant_ok  = out_ok && (out_first_slot < out_second_slot);
  assign out_no_slots  = (out_first_slot == '0) && (out_second_slot == '0);
  assign out_in_pool   = (out_first_slot <= SLOT_MAX) && (out_second_slot <= SLOT_MAX);

  // a nonzero lease only comes from a granted pair, lower slot first
  `EPLA_ASSERT_IMPLY(a_lease_means_grant, clk, rst_n, out_valid && out_has_lease, out_grant_ok)
  // results other than a grant carry no slots
  `EPLA_ASSERT_IMPLY(a_no_lease_no_slots, clk, rst_n, out_valid && !out_has_lease, out_no_slots)
  `EPLA_ASSERT_IMPLY(a_slots_in_pool, clk, rst_n, out_valid, out_in_pool)
  // a full queue stays full until the execution unit takes a command
  `EPLA_ASSERT_NEXT(a_full_holds, clk, rst_n, !in_ready && !q_pop, !in_ready)

endmodule

@@ sim/event_pair_lease_allocator_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the event pair lease allocator: directed and random requests.
module event_pair_lease_allocator_tb;
  import epla_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int NSLOT       = EVENT_COUNT_DEF;
  localparam int IDLE_PCT    = 21;
  localparam int RANDOM_REQS = 700;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;
  localparam int MAX_PRINTS  = 40;

  typedef struct {
    logic [1:0]         kind;
    logic [SLOT_W-1:0]  first_index;
    logic [SLOT_W-1:0]  second_index;
    logic [LEASE_W-1:0] lease;
  } alloc_req_t;

  typedef struct {
    logic [1:0]         kind;
    logic               ok;
    logic [SLOT_W-1:0]  first_slot;
    logic [SLOT_W-1:0]  second_slot;
    logic [LEASE_W-1:0] lease;
  } alloc_result_t;

  typedef struct {
    logic [SLOT_W-1:0]  lo;
    logic [SLOT_W-1:0]  hi;
    logic [LEASE_W-1:0] lease;
  } lease_pair_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_req_type = REQ_INIT;
  logic [SLOT_W-1:0]  in_first_index = '0;
  logic [SLOT_W-1:0]  in_second_index = '0;
  logic [LEASE_W-1:0] in_lease_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_ok;
  logic [SLOT_W-1:0]  out_first_slot;
  logic [SLOT_W-1:0]  out_second_slot;
  logic [LEASE_W-1:0] out_lease_out;

  alloc_req_t    req_backlog[$];
  alloc_result_t grant_expect_q[$];
  lease_pair_t   held_pairs[$];
  alloc_req_t    on_bus;
  bit            no_idle = 1'b0;

  // predictor state
  bit               slot_busy [NSLOT];
  bit [LEASE_W-1:0] slot_tok [NSLOT];
  bit [LEASE_W-1:0] next_tok = '0;
  bit               pool_up = 1'b0;

  int mismatches = 0;
  int reqs_taken = 0;
  int results_seen = 0;
  int n_inits = 0;
  int n_grants = 0;
  int n_full = 0;
  int n_freed = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  event_pair_lease_allocator uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_first_index (in_first_index),
    .in_second_index(in_second_index),
    .in_lease_in    (in_lease_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ok         (out_ok),
    .out_first_slot (out_first_slot),
    .out_second_slot(out_second_slot),
    .out_lease_out  (out_lease_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic alloc_result_t grant_predict(alloc_req_t r);
    alloc_result_t res;
    int lo;
    int hi;
    int found;
    res.kind        = r.kind;
    res.ok          = 1'b0;
    res.first_slot  = '0;
    res.second_slot = '0;
    res.lease       = '0;
    case (r.kind)
      REQ_INIT: begin
        for (int i = 0; i < NSLOT; i++) begin
          slot_busy[i] = 1'b0;
          slot_tok[i]  = '0;
        end
        next_tok = 1;
        pool_up  = 1'b1;
        res.ok   = 1'b1;
        n_inits++;
      end
      REQ_RESERVE: if (pool_up) begin
        lo = 0;
        hi = 0;
        found = 0;
        for (int i = 0; i < NSLOT && found < 2; i++) begin
          if (!slot_busy[i]) begin
            if (found == 0) lo = i;
            else hi = i;
            found++;
          end
        end
        if (found == 2) begin
          // token 0 is never granted
          if (next_tok == 0) next_tok = 1;
          slot_busy[lo] = 1'b1;
          slot_busy[hi] = 1'b1;
          slot_tok[lo]  = next_tok;
          slot_tok[hi]  = next_tok;
          res.ok          = 1'b1;
          res.first_slot  = lo[SLOT_W-1:0];
          res.second_slot = hi[SLOT_W-1:0];
          res.lease       = next_tok;
          next_tok = next_tok + 1;
          n_grants++;
        end else begin
          n_full++;
        end
      end
      REQ_RELEASE: begin
        if (pool_up && r.first_index < NSLOT && r.second_index < NSLOT &&
            r.first_index != r.second_index && r.lease != 0) begin
          if (slot_busy[r.first_index] && slot_busy[r.second_index] &&
              slot_tok[r.first_index] == r.lease && slot_tok[r.second_index] == r.lease) begin
            slot_busy[r.first_index]  = 1'b0;
            slot_busy[r.second_index] = 1'b0;
            slot_tok[r.first_index]   = '0;
            slot_tok[r.second_index]  = '0;
            res.ok = 1'b1;
            n_freed++;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic push_req(input logic [1:0] kind, input int a, input int b,
                          input logic [LEASE_W-1:0] tok);
    alloc_req_t rq;
    rq.kind         = kind;
    rq.first_index  = a[SLOT_W-1:0];
    rq.second_index = b[SLOT_W-1:0];
    rq.lease        = tok;
    req_backlog.push_back(rq);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        grant_expect_q.push_back(grant_predict(on_bus));
        reqs_taken++;
      end
      if (!in_valid || in_ready) begin
        if (req_backlog.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          on_bus = req_backlog.pop_front();
          in_valid        <= 1'b1;
          in_req_type     <= on_bus.kind;
          in_first_index  <= on_bus.first_index;
          in_second_index <= on_bus.second_index;
          in_lease_in     <= on_bus.lease;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk) begin : rx
    alloc_result_t want;
    lease_pair_t   pr;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (grant_expect_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = grant_expect_q.pop_front();
          if (out_ok !== want.ok)
            report_mismatch($sformatf("result %0d kind %0d: ok %b, want %b",
                                      results_seen, want.kind, out_ok, want.ok));
          if (out_first_slot !== want.first_slot)
            report_mismatch($sformatf("result %0d: first_slot %0d, want %0d",
                                      results_seen, out_first_slot, want.first_slot));
          if (out_second_slot !== want.second_slot)
            report_mismatch($sformatf("result %0d: second_slot %0d, want %0d",
                                      results_seen, out_second_slot, want.second_slot));
          if (out_lease_out !== want.lease)
            report_mismatch($sformatf("result %0d: lease_out %h, want %h",
                                      results_seen, out_lease_out, want.lease));
          // keep the generator's view of live pairs in step with the results
          if (want.kind == REQ_INIT && want.ok) begin
            held_pairs.delete();
          end else if (want.kind == REQ_RESERVE && want.ok) begin
            pr.lo    = want.first_slot;
            pr.hi    = want.second_slot;
            pr.lease = want.lease;
            held_pairs.push_back(pr);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 240) begin
        // long back-pressure so the request queue fills and in_ready drops
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("event_pair_lease_allocator_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    alloc_req_t  rq;
    lease_pair_t p;
    int          r;
    int          pick;
    bit          fill_phase;
    bit          spoiled;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // everything fails before initialize
    push_req(REQ_RESERVE, 0, 0, 0);
    push_req(REQ_RELEASE, 0, 1, 1);
    push_req(REQ_UNKNOWN, 0, 1, 1);
    push_req(REQ_INIT, 0, 0, 0);
    push_req(REQ_RESERVE, 0, 0, 0);
    push_req(REQ_RESERVE, 255, 255, 32'hFFFF_FFFF);
    push_req(REQ_RELEASE, 0, 1, 1);
    push_req(REQ_RESERVE, 0, 0, 0);              // lowest free pair reused
    push_req(REQ_RELEASE, 2, 3, 3);              // wrong lease
    push_req(REQ_RELEASE, 2, 2, 2);              // same slot twice
    push_req(REQ_RELEASE, 255, 3, 2);            // index far out of range
    push_req(REQ_RELEASE, 2, NSLOT, 2);          // index just past the pool
    push_req(REQ_RELEASE, 2, 3, 0);              // zero lease
    push_req(REQ_RELEASE, 0, 3, 3);              // slots from two pairs
    push_req(REQ_RELEASE, 3, 2, 2);              // swapped order is fine
    push_req(REQ_RELEASE, 3, 2, 2);              // already free
    push_req(REQ_UNKNOWN, 255, 255, 32'hFFFF_FFFF);
    push_req(REQ_RELEASE, NSLOT - 1, NSLOT - 2, 32'hFFFF_FFFF);
    push_req(REQ_INIT, 255, 255, 32'hFFFF_FFFF); // re-init while a pair is held
    push_req(REQ_RELEASE, 0, 1, 3);              // cleared by re-init
    push_req(REQ_RESERVE, 0, 0, 0);              // counter restarted

    for (int n = 0; n < RANDOM_REQS; n++) begin
      while (req_backlog.size() >= 4) @(negedge clk);
      // alternate pool-filling and pool-draining phases
      fill_phase = ((n / 150) % 2) == 0;
      no_idle = (n >= 450 && n < 560);
      r = $urandom_range(0, 99);
      rq.kind         = REQ_RESERVE;
      rq.first_index  = $urandom_range(0, 255);
      rq.second_index = $urandom_range(0, 255);
      rq.lease        = $urandom();
      if (!fill_phase && r < 3) begin
        rq.kind = REQ_INIT;
      end else if (r < (fill_phase ? 70 : 30)) begin
        rq.kind = REQ_RESERVE;
      end else if (r < 92 && held_pairs.size() != 0) begin
        pick = $urandom_range(0, held_pairs.size() - 1);
        p = held_pairs[pick];
        held_pairs.delete(pick);
        rq.kind  = REQ_RELEASE;
        rq.lease = p.lease;
        if ($urandom_range(0, 1)) begin
          rq.first_index  = p.hi;
          rq.second_index = p.lo;
        end else begin
          rq.first_index  = p.lo;
          rq.second_index = p.hi;
        end
        spoiled = 1'b1;
        case ($urandom_range(0, 11))
          0: rq.lease = rq.lease ^ (32'h1 << $urandom_range(0, 31));
          1: rq.lease = '0;
          2: rq.second_index = rq.first_index;
          3: rq.first_index = $urandom_range(NSLOT, 255);
          4: rq.second_index = rq.second_index + 8'd1;
          default: spoiled = 1'b0;
        endcase
        // a broken release leaves the pair held
        if (spoiled) held_pairs.push_back(p);
      end else begin
        case (r % 3)
          0:       rq.kind = REQ_UNKNOWN;
          1:       rq.kind = REQ_RESERVE;
          default: rq.kind = REQ_RELEASE;
        endcase
      end
      req_backlog.push_back(rq);
    end

    while (req_backlog.size() != 0 || in_valid) @(negedge clk);
    while (grant_expect_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("run: %0d requests, %0d results; %0d initializes, %0d pairs granted,",
             reqs_taken, results_seen, n_inits, n_grants);
    $display("     %0d reserves refused on a full pool, %0d pairs released, %0d mismatches",
             n_full, n_freed, mismatches);
    if (mismatches == 0 && grant_expect_q.size() == 0) begin
      $display("event_pair_lease_allocator_tb: PASS");
    end else begin
      $display("event_pair_lease_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule
